// ----- hdl/framed_command_receiver_crc16_unit_macros.svh -----
// Assertion macros shared by the receiver RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef FRAMED_COMMAND_RECEIVER_CRC16_UNIT_MACROS_SVH
`define FRAMED_COMMAND_RECEIVER_CRC16_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define FCR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FCR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FCR_ASSERT_IMP(lbl, ante, cons)
`define FCR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/fcr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fcr_pkg;

    localparam logic [7:0]  FRAME_START       = 8'hAA;
    localparam logic [7:0]  FRAME_END         = 8'h55;
    localparam logic [7:0]  OWN_ADDRESS_RESET = 8'h20;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'h1021;

    localparam int PAYLOAD_BYTES = 8;
    localparam int HALF_W        = 32;
    localparam int OUT_FIELDS_W  = 2 + 8 + 2 * HALF_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    // byte positions within a frame; hunting for start at zero
    localparam logic [3:0] POS_HUNT     = 4'd0;
    localparam logic [3:0] POS_ADDR     = 4'd1;
    localparam logic [3:0] POS_CMD      = 4'd2;
    localparam logic [3:0] POS_PAY0     = 4'd3;
    localparam logic [3:0] POS_PAY_LAST = 4'd10;
    localparam logic [3:0] POS_CRC_HI   = 4'd11;
    localparam logic [3:0] POS_CRC_LO   = 4'd12;
    localparam logic [3:0] POS_END      = 4'd13;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT  = 2'd0,
        VERDICT_REJECT  = 2'd1,
        VERDICT_CRC_ERR = 2'd2
    } fcr_verdict_t;

    typedef struct packed {
        logic                last_byte;
        fcr_verdict_t        verdict;
        logic [7:0]          command_code;
        logic [HALF_W-1:0]   payload_first_half;
        logic [HALF_W-1:0]   payload_second_half;
    } fcr_result_t;

    // CRC-16-CCITT, MSB first, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/fcr_frame_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "framed_command_receiver_crc16_unit_macros.svh"

module fcr_frame_tracker
    import fcr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [7:0]  own_address,
    output fcr_result_t      result
);

    logic [3:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic        addr_match_reg, addr_match_next;
    logic [7:0]  command_reg, command_next;
    logic [PAYLOAD_BYTES-1:0][7:0] payload_reg, payload_next;
    logic [15:0] rx_crc_reg, rx_crc_next;

    logic [15:0] crc_fed;
    logic [3:0]  pay_off;
    logic [2:0]  pay_idx;
    logic        accept;

    assign crc_fed = crc_feed(crc_reg, rx_byte);
    assign pay_off = pos_reg - POS_PAY0;
    assign pay_idx = pay_off[2:0];

    always_comb
    begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        addr_match_next = addr_match_reg;
        command_next    = command_reg;
        payload_next    = payload_reg;
        rx_crc_next     = rx_crc_reg;
        if (step)
        begin
            priority if (pos_reg == POS_HUNT)
            begin
                if (rx_byte == FRAME_START)
                begin
                    crc_next = CRC_INIT;
                    pos_next = POS_ADDR;
                end
            end
            else if (pos_reg == POS_ADDR)
            begin
                crc_next        = crc_fed;
                addr_match_next = (rx_byte == own_address);
                pos_next        = POS_CMD;
            end
            else if (pos_reg == POS_CMD)
            begin
                crc_next     = crc_fed;
                command_next = rx_byte;
                pos_next     = POS_PAY0;
            end
            else if (pos_reg <= POS_PAY_LAST)
            begin
                crc_next              = crc_fed;
                payload_next[pay_idx] = rx_byte;
                pos_next              = pos_reg + 4'd1;
            end
            else if (pos_reg == POS_CRC_HI)
            begin
                rx_crc_next[15:8] = rx_byte;
                pos_next          = POS_CRC_LO;
            end
            else if (pos_reg == POS_CRC_LO)
            begin
                rx_crc_next[7:0] = rx_byte;
                pos_next         = POS_END;
            end
            else
            begin
                // end byte, or a position that should never occur
                pos_next = POS_HUNT;
                crc_next = CRC_INIT;
            end
        end
    end

    always_comb
    begin
        result.last_byte = (pos_reg == POS_END);
        if (rx_byte != FRAME_END || !addr_match_reg)
            result.verdict = VERDICT_REJECT;
        else if (crc_reg != rx_crc_reg)
            result.verdict = VERDICT_CRC_ERR;
        else
            result.verdict = VERDICT_ACCEPT;
        accept = (result.verdict == VERDICT_ACCEPT);
        result.command_code        = accept ? command_reg : 8'h00;
        result.payload_first_half  = accept ? payload_reg[3:0] : '0;
        result.payload_second_half = accept ? payload_reg[7:4] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_HUNT;
            crc_reg        <= CRC_INIT;
            addr_match_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            addr_match_reg <= addr_match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        command_reg <= command_next;
        payload_reg <= payload_next;
        rx_crc_reg  <= rx_crc_next;
    end

    `FCR_ASSERT_IMP(a_pos_in_range, 1'b1, pos_reg <= POS_END)
    `FCR_ASSERT_NEXT(a_end_rearms, step && pos_reg == POS_END,
        pos_reg == POS_HUNT && crc_reg == CRC_INIT)
    `FCR_ASSERT_NEXT(a_hold_when_idle, !step, $stable(pos_reg) && $stable(crc_reg))
    `FCR_ASSERT_NEXT(a_start_seen, step && pos_reg == POS_HUNT && rx_byte == FRAME_START,
        pos_reg == POS_ADDR && crc_reg == CRC_INIT)

endmodule

`default_nettype wire

// ----- hdl/framed_command_receiver_crc16_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "framed_command_receiver_crc16_unit_macros.svh"

// The end byte is held in the input register; its verdict is then registered for m_axis.
// Throughput: one byte per cycle, stalled while an end byte waits on a full output register;
// the CRC byte update and frame counter step share a cycle. The input register keeps accepting
// while a verdict waits in the output register. Reset (rst_n low, asynchronous): hunting for
// start, CRC 0xFFFF, own_address 0x20, both stages empty.
module framed_command_receiver_crc16_unit
    import fcr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output      logic                   s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // rx_byte
    output      logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // verdict[1:0], command_code[9:2], payload_first_half[41:10],
    // payload_second_half[73:42], zero fill above
    output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [7:0]             cfg_data        // own_address
);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg, in_byte_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [7:0]             own_addr_reg, own_addr_next;

    logic        out_free;
    logic        advance;
    logic        emit;
    fcr_result_t result;

    fcr_frame_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .rx_byte     (in_byte_reg),
        .own_address (own_addr_reg),
        .result      (result)
    );

    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!result.last_byte || out_free);
    assign emit          = advance && result.last_byte;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        own_addr_next  = own_addr_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;
        if (s_axis_tvalid && s_axis_tready)
            in_byte_next = s_axis_tdata;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{OUT_PAD_W{1'b0}}, result.payload_second_half,
                              result.payload_first_half, result.command_code,
                              result.verdict};
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        if (cfg_valid && cfg_ready)
            own_addr_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            own_addr_reg  <= OWN_ADDRESS_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            own_addr_reg  <= own_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg  <= in_byte_next;
        out_data_reg <= out_data_next;
    end

    `FCR_ASSERT_IMP(a_reject_clears_fields,
        out_valid_reg && out_data_reg[1:0] != VERDICT_ACCEPT,
        out_data_reg[OUT_TDATA_W-1:2] == '0)
    `FCR_ASSERT_NEXT(a_input_held, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg))
    `FCR_ASSERT_IMP(a_emit_needs_room, emit, out_free)

endmodule

`default_nettype wire
